// ----- rtl/ppdm_pkg.sv -----
`default_nettype none

package ppdm_pkg;

  // Field widths
  localparam int unsigned TimerBits = 16;
  localparam int unsigned LimitBits = 16;
  localparam int unsigned DutyBits  = 7;
  localparam int unsigned ClassBits = 2;

  // Quotient bits computed by the divider; high*100 fits TimerBits + DutyBits
  localparam int unsigned QuotBits  = 7;
  localparam int unsigned RemBits   = TimerBits + DutyBits;
  localparam int unsigned CntBits   = 3;

  // APB register map
  localparam int unsigned AddrBits  = 4;
  localparam int unsigned DataBits  = 32;
  localparam logic [1:0] RegLongLimit  = 2'd0;
  localparam logic [1:0] RegMidLimit   = 2'd1;
  localparam logic [1:0] RegShortLimit = 2'd2;

  localparam logic [LimitBits-1:0] LongLimitRst  = 16'd3125;
  localparam logic [LimitBits-1:0] MidLimitRst   = 16'd1563;
  localparam logic [LimitBits-1:0] ShortLimitRst = 16'd781;

  // Duty constants
  localparam logic [DutyBits-1:0] DutyFull = 7'd100;
  localparam logic [DutyBits-1:0] DutyQ1   = 7'd25;
  localparam logic [DutyBits-1:0] DutyQ2   = 7'd50;
  localparam logic [DutyBits-1:0] DutyQ3   = 7'd75;

  // Class codes
  localparam logic [ClassBits-1:0] Class0 = 2'd0;
  localparam logic [ClassBits-1:0] Class1 = 2'd1;
  localparam logic [ClassBits-1:0] Class2 = 2'd2;
  localparam logic [ClassBits-1:0] Class3 = 2'd3;

  // Microcode
  localparam int unsigned PcBits = 3;

  localparam logic [2:0] OpNop    = 3'd0;
  localparam logic [2:0] OpWait   = 3'd1;
  localparam logic [2:0] OpUpdate = 3'd2;
  localparam logic [2:0] OpPrep   = 3'd3;
  localparam logic [2:0] OpDiv    = 3'd4;
  localparam logic [2:0] OpEmit   = 3'd5;

  localparam logic [2:0] CondNever    = 3'd0;
  localparam logic [2:0] CondAlways   = 3'd1;
  localparam logic [2:0] CondNoInput  = 3'd2;
  localparam logic [2:0] CondShortcut = 3'd3;
  localparam logic [2:0] CondLoop     = 3'd4;
  localparam logic [2:0] CondOutBusy  = 3'd5;

  localparam logic [PcBits-1:0] PcWait = 3'd0;
  localparam logic [PcBits-1:0] PcDiv  = 3'd3;
  localparam logic [PcBits-1:0] PcEmit = 3'd4;

  typedef struct packed {
    logic [2:0]        op;
    logic [2:0]        cond;
    logic [PcBits-1:0] target;
  } ctrl_word_t;

  // Jump to target when the condition holds, else advance
  function automatic ctrl_word_t ucode_rom(input logic [PcBits-1:0] pc);
    ctrl_word_t w;
    unique case (pc)
      3'd0:    w = '{op: OpWait,   cond: CondNoInput,  target: PcWait};
      3'd1:    w = '{op: OpUpdate, cond: CondNever,    target: PcWait};
      3'd2:    w = '{op: OpPrep,   cond: CondShortcut, target: PcEmit};
      3'd3:    w = '{op: OpDiv,    cond: CondLoop,     target: PcDiv};
      3'd4:    w = '{op: OpEmit,   cond: CondOutBusy,  target: PcEmit};
      default: w = '{op: OpNop,    cond: CondAlways,   target: PcWait};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ppdm_event_if.sv -----
`default_nettype none

interface ppdm_event_if import ppdm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [TimerBits-1:0] capture_time;
  logic                 pin_level;

  modport source (output valid, capture_time, pin_level, input ready);
  modport sink   (input valid, capture_time, pin_level, output ready);
endinterface

`default_nettype wire

// ----- rtl/ppdm_result_if.sv -----
`default_nettype none

interface ppdm_result_if import ppdm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [TimerBits-1:0] period_ticks;
  logic [TimerBits-1:0] high_ticks;
  logic [DutyBits-1:0]  duty_percent;
  logic [ClassBits-1:0] period_class;
  logic [ClassBits-1:0] duty_class;

  modport source (output valid, period_ticks, high_ticks, duty_percent, period_class,
                  duty_class, input ready);
  modport sink   (input valid, period_ticks, high_ticks, duty_percent, period_class,
                  duty_class, output ready);
endinterface

`default_nettype wire

// ----- rtl/pwm_period_duty_meter.sv -----
// PWM period and duty meter. Each input word is one captured pin edge: the
// 16-bit timer stamp and the pin level after the edge (1 rising, 0 falling).
// A rising edge sets the period to the time since the previous rising edge
// (modulo 2^16) and becomes the new reference; a falling edge sets the high
// time to the time since the last rising edge. Every edge yields one result
// word with period, high time, duty percent (floor of high*100/period,
// 100 when high >= period, 0 when period is 0), a period class from the three
// APB limit registers (0 = slowest band, tested long, mid, short in turn) and
// a duty class at 25/50/75 percent. Before the first rising edge the
// reference time is 0. A short microcoded sequencer steps a small datapath:
// accept, update, prepare, seven restoring division steps, emit, return.
// An edge whose duty is 0 or saturates skips the division and goes from
// prepare straight to emit. The result sits in an output register, so the
// next edge is accepted while the previous result waits. Write limits only
// while idle.
`default_nettype none

module pwm_period_duty_meter import ppdm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  ppdm_event_if.sink          evt_i,
  ppdm_result_if.source       res_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [DataBits-1:0] pwdata,
  output logic [DataBits-1:0] prdata,
  output logic                pready
);

  // ---------------------------------------------------------------------
  // Limit registers
  // ---------------------------------------------------------------------
  logic [LimitBits-1:0] long_lim_q, mid_lim_q, short_lim_q;
  logic                 cfg_wr;
  logic [1:0]           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_lim_q  <= LongLimitRst;
      mid_lim_q   <= MidLimitRst;
      short_lim_q <= ShortLimitRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegLongLimit:  long_lim_q  <= pwdata[LimitBits-1:0];
        RegMidLimit:   mid_lim_q   <= pwdata[LimitBits-1:0];
        RegShortLimit: short_lim_q <= pwdata[LimitBits-1:0];
        default: ;  // drop writes beyond the map
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegLongLimit:  prdata = DataBits'(long_lim_q);
      RegMidLimit:   prdata = DataBits'(mid_lim_q);
      RegShortLimit: prdata = DataBits'(short_lim_q);
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: step counter plus control ROM
  // ---------------------------------------------------------------------
  logic [PcBits-1:0] pc_q, pc_d;
  ctrl_word_t        cw;
  logic              cond_hit;

  // Datapath registers
  logic [TimerBits-1:0] time_q;
  logic                 level_q;
  logic [TimerBits-1:0] last_rise_q, period_q, high_q;
  logic [RemBits-1:0]   rem_q, dvs_q;
  logic [QuotBits-1:0]  quot_q;
  logic [CntBits-1:0]   cnt_q;

  // Output register
  logic                 out_valid_q;
  logic [TimerBits-1:0] out_period_q, out_high_q;
  logic [DutyBits-1:0]  out_duty_q;
  logic [ClassBits-1:0] out_pclass_q, out_dclass_q;

  logic                 in_take;
  logic                 out_busy;
  logic                 shortcut;
  logic                 rem_ge;
  logic [TimerBits-1:0] delta;
  logic [ClassBits-1:0] pclass, dclass;

  assign cw       = ucode_rom(pc_q);
  assign in_take  = (cw.op == OpWait) && evt_i.valid;
  assign out_busy = out_valid_q && !res_o.ready;
  // Zero period gives duty 0; high >= period saturates at 100
  assign shortcut = (period_q == '0) || (high_q >= period_q);
  assign rem_ge   = (rem_q >= dvs_q);
  assign delta    = time_q - last_rise_q;

  always_comb begin
    unique case (cw.cond)
      CondNever:    cond_hit = 1'b0;
      CondAlways:   cond_hit = 1'b1;
      CondNoInput:  cond_hit = !evt_i.valid;
      CondShortcut: cond_hit = shortcut;
      CondLoop:     cond_hit = (cnt_q != '0);
      CondOutBusy:  cond_hit = out_busy;
      default:      cond_hit = 1'b1;
    endcase
    pc_d = cond_hit ? cw.target : pc_q + PcBits'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PcWait;
    end else begin
      pc_q <= pc_d;
    end
  end

  // ---------------------------------------------------------------------
  // Measurement state
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_rise_q <= '0;
      period_q    <= '0;
      high_q      <= '0;
    end else if (cw.op == OpUpdate) begin
      if (level_q) begin
        period_q    <= delta;
        last_rise_q <= time_q;
      end else begin
        high_q <= delta;
      end
    end
  end

  // Capture, division and step count; payload only, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      time_q  <= evt_i.capture_time;
      level_q <= evt_i.pin_level;
    end
    if (cw.op == OpPrep) begin
      rem_q  <= RemBits'(high_q) * RemBits'(DutyFull);
      dvs_q  <= RemBits'({period_q, (QuotBits - 1)'(0)});
      cnt_q  <= CntBits'(QuotBits - 1);
      // Saturated duty loads full scale; zero period and a real division start at 0
      if (shortcut && (period_q != '0)) begin
        quot_q <= QuotBits'(DutyFull);
      end else begin
        quot_q <= '0;
      end
    end else if (cw.op == OpDiv) begin
      // One restoring step: trial subtract, shift in the quotient bit
      if (rem_ge) begin
        rem_q <= rem_q - dvs_q;
      end
      quot_q <= {quot_q[QuotBits-2:0], rem_ge};
      dvs_q  <= dvs_q >> 1;
      cnt_q  <= cnt_q - CntBits'(1);
    end
  end

  // ---------------------------------------------------------------------
  // Classes and result register
  // ---------------------------------------------------------------------
  always_comb begin
    priority if (period_q > long_lim_q) begin
      pclass = Class0;
    end else if (period_q > mid_lim_q) begin
      pclass = Class1;
    end else if (period_q > short_lim_q) begin
      pclass = Class2;
    end else begin
      pclass = Class3;
    end
    priority if (quot_q < DutyQ1) begin
      dclass = Class0;
    end else if (quot_q < DutyQ2) begin
      dclass = Class1;
    end else if (quot_q < DutyQ3) begin
      dclass = Class2;
    end else begin
      dclass = Class3;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cw.op == OpEmit) && !out_busy) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((cw.op == OpEmit) && !out_busy) begin
      out_period_q <= period_q;
      out_high_q   <= high_q;
      out_duty_q   <= quot_q;
      out_pclass_q <= pclass;
      out_dclass_q <= dclass;
    end
  end

  assign evt_i.ready        = (cw.op == OpWait);
  assign res_o.valid        = out_valid_q;
  assign res_o.period_ticks = out_period_q;
  assign res_o.high_ticks   = out_high_q;
  assign res_o.duty_percent = out_duty_q;
  assign res_o.period_class = out_pclass_q;
  assign res_o.duty_class   = out_dclass_q;

endmodule

`default_nettype wire

// ----- rtl/ppdm_checker.sv -----
`default_nettype none

module ppdm_checker import ppdm_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 res_valid_i,
  input logic                 res_ready_i,
  input logic [TimerBits-1:0] period_ticks_i,
  input logic [DutyBits-1:0]  duty_percent_i,
  input logic [ClassBits-1:0] duty_class_i
);

  // Hold a stalled result word
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(duty_percent_i)
      && $stable(period_ticks_i) && $stable(duty_class_i))
    else $error("result word changed while stalled");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> duty_percent_i <= DutyFull)
    else $error("duty above full scale");

  a_zero_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (period_ticks_i == '0) |-> duty_percent_i == '0)
    else $error("nonzero duty with zero period");

  a_duty_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |->
      ((duty_percent_i < DutyQ1) && (duty_class_i == Class0)) ||
      ((duty_percent_i >= DutyQ1) && (duty_percent_i < DutyQ2) &&
       (duty_class_i == Class1)) ||
      ((duty_percent_i >= DutyQ2) && (duty_percent_i < DutyQ3) &&
       (duty_class_i == Class2)) ||
      ((duty_percent_i >= DutyQ3) && (duty_class_i == Class3)))
    else $error("duty class disagrees with duty percent");

endmodule

bind pwm_period_duty_meter ppdm_checker u_ppdm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .period_ticks_i (res_o.period_ticks),
  .duty_percent_i (res_o.duty_percent),
  .duty_class_i   (res_o.duty_class)
);

`default_nettype wire

// ----- test/pwm_period_duty_meter_tb.sv -----
`default_nettype none

module pwm_period_duty_meter_tb import ppdm_pkg::*; ();

  // Timeout in clock cycles; the slowest correct run stays well under it.
  localparam int unsigned CycleLimit  = 400_000;
  // Quiet cycles after the last result word before limits change or the run ends.
  localparam int unsigned DrainCycles = 30;
  // Length of the one long receiver hold-off that backs the block up.
  localparam int unsigned HoldCycles  = 300;
  // Index past the end of the register map; writes there must be dropped.
  localparam logic [1:0]  RegUnmapped = 2'd3;

  typedef struct packed {
    logic [TimerBits-1:0] period_ticks;
    logic [TimerBits-1:0] high_ticks;
    logic [DutyBits-1:0]  duty_percent;
    logic [ClassBits-1:0] period_class;
    logic [ClassBits-1:0] duty_class;
  } meter_reading_t;

  // Shadow of the meter: limits, last rising stamp, held period and high time,
  // plus the readings still owed by the block in arrival order.
  class meter_scoreboard;
    logic [LimitBits-1:0] long_lim, mid_lim, short_lim;
    logic [TimerBits-1:0] rise_stamp, period_q, high_q;
    meter_reading_t       owed_q[$];
    int unsigned          errors;

    function new();
      long_lim   = LongLimitRst;
      mid_lim    = MidLimitRst;
      short_lim  = ShortLimitRst;
      rise_stamp = '0;
      period_q   = '0;
      high_q     = '0;
      errors     = 0;
    endfunction

    function void set_limit(logic [1:0] idx, logic [LimitBits-1:0] val);
      case (idx)
        RegLongLimit:  long_lim  = val;
        RegMidLimit:   mid_lim   = val;
        RegShortLimit: short_lim = val;
        default: ;
      endcase
    endfunction

    function logic [LimitBits-1:0] limit_of(logic [1:0] idx);
      case (idx)
        RegLongLimit:  return long_lim;
        RegMidLimit:   return mid_lim;
        default:       return short_lim;
      endcase
    endfunction

    // Thresholds apply in a fixed order even when they are out of order.
    function logic [ClassBits-1:0] period_band(logic [TimerBits-1:0] p);
      if (p > long_lim) return Class0;
      if (p > mid_lim) return Class1;
      if (p > short_lim) return Class2;
      return Class3;
    endfunction

    function logic [ClassBits-1:0] duty_band(logic [DutyBits-1:0] d);
      if (d < DutyQ1) return Class0;
      if (d < DutyQ2) return Class1;
      if (d < DutyQ3) return Class2;
      return Class3;
    endfunction

    function void note_edge(logic [TimerBits-1:0] stamp, logic level);
      logic [TimerBits-1:0] elapsed;
      int unsigned          ratio;
      meter_reading_t       r;
      elapsed = stamp - rise_stamp;  // wraps modulo the timer width
      if (level) begin
        period_q   = elapsed;
        rise_stamp = stamp;
      end else begin
        high_q = elapsed;
      end
      if (period_q == '0) begin
        ratio = 0;
      end else begin
        ratio = (32'(high_q) * 100) / 32'(period_q);
      end
      if (ratio > DutyFull) ratio = DutyFull;
      r.period_ticks = period_q;
      r.high_ticks   = high_q;
      r.duty_percent = ratio[DutyBits-1:0];
      r.period_class = period_band(period_q);
      r.duty_class   = duty_band(r.duty_percent);
      owed_q.push_back(r);
    endfunction

    function void check_reading(meter_reading_t got);
      meter_reading_t want;
      if (owed_q.size() == 0) begin
        $error("result word with nothing owed: period %0d high %0d",
               got.period_ticks, got.high_ticks);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.period_ticks !== want.period_ticks) begin
        $error("period_ticks expected %0d got %0d", want.period_ticks, got.period_ticks);
        errors++;
      end
      if (got.high_ticks !== want.high_ticks) begin
        $error("high_ticks expected %0d got %0d", want.high_ticks, got.high_ticks);
        errors++;
      end
      if (got.duty_percent !== want.duty_percent) begin
        $error("duty_percent expected %0d got %0d", want.duty_percent, got.duty_percent);
        errors++;
      end
      if (got.period_class !== want.period_class) begin
        $error("period_class expected %0d got %0d", want.period_class, got.period_class);
        errors++;
      end
      if (got.duty_class !== want.duty_class) begin
        $error("duty_class expected %0d got %0d", want.duty_class, got.duty_class);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrBits-1:0] paddr;
  logic [DataBits-1:0] pwdata;
  logic [DataBits-1:0] prdata;
  logic                pready;

  ppdm_event_if  evt_bus ();
  ppdm_result_if res_bus ();

  meter_scoreboard      sb;
  int unsigned          cycle_count;
  int unsigned          tx_gap_max;     // upper bound of the sender's per-word gap
  int unsigned          rx_gap_max;     // upper bound of the receiver's per-word stall
  int unsigned          rx_hold_cycles; // nonzero asks the receiver for one long hold
  logic [TimerBits-1:0] wave_stamp;     // running timer stamp of the random waveforms

  pwm_period_duty_meter u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .evt_i   (evt_bus),
    .res_o   (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Send one edge word. Enter and leave on a falling edge; valid stays high
  // on the way out so back-to-back words need no second assignment.
  task automatic send_edge(input logic [TimerBits-1:0] stamp, input logic level);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      evt_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    evt_bus.capture_time = stamp;
    evt_bus.pin_level    = level;
    evt_bus.valid        = 1'b1;
    @(posedge clk);
    while (!evt_bus.ready) @(posedge clk);
    sb.note_edge(stamp, level);
    @(negedge clk);
  endtask

  // Drop valid, wait for every owed reading, then let the block go quiet.
  task automatic settle();
    evt_bus.valid = 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle; the register takes it at the
  // rising edge that sees psel, penable, pwrite and pready all high.
  task automatic write_limit(input logic [1:0] idx, input logic [LimitBits-1:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {16'($urandom()), val};  // upper bits are junk the block must drop
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_limit(idx, val);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic read_limit(input logic [1:0] idx);
    logic [LimitBits-1:0] got;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata[LimitBits-1:0];
    if (got !== sb.limit_of(idx)) begin
      $error("limit register %0d expected %0d got %0d", idx, sb.limit_of(idx), got);
      sb.errors++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic program_limits(input logic [LimitBits-1:0] long_v,
                                input logic [LimitBits-1:0] mid_v,
                                input logic [LimitBits-1:0] short_v);
    write_limit(RegLongLimit, long_v);
    write_limit(RegMidLimit, mid_v);
    write_limit(RegShortLimit, short_v);
    read_limit(RegLongLimit);
    read_limit(RegMidLimit);
    read_limit(RegShortLimit);
  endtask

  // Favor periods that sit right on a class threshold, then short ones,
  // and now and then any value of the timer.
  function automatic logic [TimerBits-1:0] pick_period();
    int pick;
    int lim;
    int v;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      case ($urandom_range(0, 2))
        0:       lim = int'(sb.long_lim);
        1:       lim = int'(sb.mid_lim);
        default: lim = int'(sb.short_lim);
      endcase
      v = lim + int'($urandom_range(0, 6)) - 3;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
    end else if (pick < 8) begin
      v = int'($urandom_range(1, 4000));
    end else begin
      v = int'($urandom_range(0, 65535));
    end
    return v[TimerBits-1:0];
  endfunction

  // Mostly high times inside the period, with quarter points for the duty
  // class edges, zero high time and high times equal to or longer than the period.
  function automatic logic [TimerBits-1:0] pick_high(input logic [TimerBits-1:0] period);
    int p;
    int v;
    p = int'(period);
    case ($urandom_range(0, 7))
      0:       v = 0;
      1:       v = p + int'($urandom_range(1, 300));
      2:       v = (p * int'($urandom_range(1, 3))) / 4;
      3:       v = p;
      default: v = int'($urandom_range(0, p));
    endcase
    return v[TimerBits-1:0];
  endfunction

  // Random part: mostly clean PWM trains (rise, fall, rise ...) with random
  // period, duty and start, running on across the timer wrap; the rest is
  // noise with random stamps and levels, which also gives doubled edges.
  task automatic run_waveforms(input int unsigned n_words);
    int unsigned          sent;
    int unsigned          reps;
    logic [TimerBits-1:0] period;
    logic [TimerBits-1:0] high;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(0, 4) == 0) begin
        reps = $urandom_range(1, 4);
        repeat (reps) begin
          send_edge(16'($urandom()), 1'($urandom()));
          sent++;
        end
      end else begin
        if ($urandom_range(0, 3) == 0) wave_stamp = 16'($urandom());
        period = pick_period();
        high   = pick_high(period);
        reps   = $urandom_range(2, 6);
        repeat (reps) begin
          send_edge(wave_stamp, 1'b1);
          send_edge(wave_stamp + high, 1'b0);
          wave_stamp = wave_stamp + period;
          sent += 2;
        end
      end
    end
  endtask

  // Result side: stall a random number of cycles per word, honor a long
  // hold when one is asked for, then take the next word and check it.
  initial begin : result_drain
    meter_reading_t got;
    res_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        res_bus.ready = 1'b0;
        repeat (rx_hold_cycles) @(negedge clk);
        rx_hold_cycles = 0;
      end else if (rx_gap_max > 0) begin
        int unsigned gap;
        gap = $urandom_range(0, rx_gap_max);
        if (gap > 0) begin
          res_bus.ready = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      res_bus.ready = 1'b1;
      @(posedge clk);
      while (!res_bus.valid) @(posedge clk);
      got.period_ticks = res_bus.period_ticks;
      got.high_ticks   = res_bus.high_ticks;
      got.duty_percent = res_bus.duty_percent;
      got.period_class = res_bus.period_class;
      got.duty_class   = res_bus.duty_class;
      sb.check_reading(got);
      @(negedge clk);
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    clk                  = 1'b0;
    rst_n                = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    evt_bus.valid        = 1'b0;
    evt_bus.capture_time = '0;
    evt_bus.pin_level    = 1'b0;
    tx_gap_max           = 6;
    rx_gap_max           = 6;
    rx_hold_cycles       = 0;
    wave_stamp           = '0;
    sb                   = new();

    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset limits must read back before anything is written.
    read_limit(RegLongLimit);
    read_limit(RegMidLimit);
    read_limit(RegShortLimit);

    // Directed edges at the reset limits.
    send_edge(16'd0, 1'b0);        // falling first: measured against rise time 0
    send_edge(16'd0, 1'b1);        // rising at 0: zero period, duty forced to 0
    send_edge(16'd1000, 1'b1);     // period 1000
    send_edge(16'd1250, 1'b0);     // exactly 25 percent
    send_edge(16'd2000, 1'b1);
    send_edge(16'd2249, 1'b0);     // just under 25 percent
    send_edge(16'd2500, 1'b0);     // exactly 50 percent
    send_edge(16'd2750, 1'b0);     // exactly 75 percent
    send_edge(16'd4500, 1'b0);     // high longer than period: saturate at 100
    send_edge(16'd65535, 1'b1);    // top of the timer, slowest band
    send_edge(16'd100, 1'b0);      // high time across the wrap
    send_edge(16'd300, 1'b1);      // period across the wrap
    send_edge(16'd1081, 1'b1);     // period equal to the short limit
    send_edge(16'd1863, 1'b1);     // one above the short limit
    send_edge(16'd3426, 1'b1);     // equal to the mid limit
    send_edge(16'd4990, 1'b1);     // one above the mid limit
    send_edge(16'd8115, 1'b1);     // equal to the long limit
    send_edge(16'd11241, 1'b1);    // one above the long limit
    send_edge(16'd11241, 1'b0);    // zero high time
    send_edge(16'd65535, 1'b0);    // largest stamp on a falling edge
    settle();

    // Reset limits, full idling, and one long result hold-off that fills the
    // block and stalls its input while edges keep coming.
    rx_hold_cycles = HoldCycles;
    run_waveforms(350);
    settle();

    // All limits at zero; a write past the map must change nothing.
    // Run flat out on both sides.
    program_limits(16'd0, 16'd0, 16'd0);
    write_limit(RegUnmapped, 16'($urandom()));
    read_limit(RegLongLimit);
    read_limit(RegMidLimit);
    read_limit(RegShortLimit);
    tx_gap_max = 0;
    rx_gap_max = 0;
    run_waveforms(250);
    settle();

    // All limits at the top; sender flat out, receiver stalling.
    program_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
    rx_gap_max = 6;
    run_waveforms(250);
    settle();

    // Limits out of order; sender gapping, receiver always ready.
    program_limits(16'd200, 16'd40000, 16'd1000);
    tx_gap_max = 6;
    rx_gap_max = 0;
    run_waveforms(300);
    settle();

    // Random limits, full idling on both sides.
    program_limits(16'($urandom_range(1000, 8000)), 16'($urandom_range(400, 3000)),
                   16'($urandom_range(0, 1200)));
    rx_gap_max = 6;
    run_waveforms(430);
    settle();

    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
